@@ design/mpurb_pkg.sv @@
package mpurb_pkg;

  localparam int unsigned NumPorts  = 5;
  localparam int unsigned RingDepth = 256;
  localparam int unsigned OpenBits  = 5;
  localparam int unsigned PortW     = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CntW      = 8;
  localparam int unsigned PtrW      = $clog2(RingDepth);
  localparam int unsigned PortSelW  = (NumPorts > 1) ? $clog2(NumPorts) : 1;
  localparam int unsigned AddrW     = $clog2(NumPorts * RingDepth);
  localparam int unsigned MemDepth  = NumPorts * RingDepth;
  // Ports that have a bit in the open mask.
  localparam int unsigned MaskPorts = (NumPorts < OpenBits) ? NumPorts : OpenBits;

  typedef logic [PtrW-1:0] ptr_t;

  typedef enum logic [2:0] {
    ActTxPush  = 3'd0,
    ActTxDone  = 3'd1,
    ActRxPush  = 3'd2,
    ActRxPop   = 3'd3,
    ActRxLevel = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]       action;
    logic [PortW-1:0] port_index;
    logic [ByteW-1:0] data_byte;
  } req_t;

  typedef struct packed {
    logic             accepted;
    logic             line_valid;
    logic [ByteW-1:0] line_byte;
    logic             read_valid;
    logic [ByteW-1:0] read_byte;
    logic [CntW-1:0]  rx_count;
    logic             tx_busy;
  } rsp_t;

  function automatic ptr_t bump(input ptr_t p);
    return (p == PtrW'(RingDepth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  function automatic ptr_t fill(input ptr_t w, input ptr_t r);
    logic [PtrW:0] wrapped;
    wrapped = {1'b0, w} + (PtrW+1)'(RingDepth) - {1'b0, r};
    return (w >= r) ? PtrW'(w - r) : PtrW'(wrapped);
  endfunction

  function automatic logic [AddrW-1:0] ram_addr(input logic [PortW-1:0] port, input ptr_t ptr);
    logic [AddrW-1:0] a;
    a = AddrW'(AddrW'(port) * AddrW'(RingDepth)) + AddrW'(ptr);
    return a;
  endfunction

endpackage

@@ design/mpurb_ram.sv @@
module mpurb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1280
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read-first: a read of the entry written in the same cycle returns the old data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/multi_port_uart_ring_buffers.sv @@
// Transmit and receive byte rings for several serial ports, held in two
// synchronous RAMs (one for all transmit rings, one for all receive rings).
// Requests enter on req_i and are taken at a clock edge where start_i is high
// and busy_o is low. Each request performs one action on one port: push or
// pull a transmit byte, push a received byte, pop a received byte, or query
// the receive level. Exactly one response follows, on rsp_o with done_o high
// for one cycle, in the cycle right after the request is taken; the receiver
// cannot stall it. A new request may be taken in every cycle, so throughput
// is one request per cycle: each action needs one RAM access per ring and a
// pointer update in flip-flops, and the byte read from RAM is registered by
// the RAM itself. busy_o is high only in a cycle that writes the open-mask
// register via cfg_we_i/cfg_wdata_i, and no request is taken then; opening a
// port clears its pointers and its transmit busy flag. Reset clears all pointers,
// busy flags and the open mask at once; the RAM contents are not cleared and
// need no sweep, since no entry is read before it is written.
module multi_port_uart_ring_buffers (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  mpurb_pkg::req_t                  req_i,
  output logic                             done_o,
  output mpurb_pkg::rsp_t                  rsp_o,
  input  logic                             cfg_we_i,
  input  logic [mpurb_pkg::OpenBits-1:0]   cfg_wdata_i
);

  localparam int unsigned NumPorts = mpurb_pkg::NumPorts;
  localparam int unsigned PortSelW = mpurb_pkg::PortSelW;
  localparam int unsigned AddrW    = mpurb_pkg::AddrW;
  localparam int unsigned ByteW    = mpurb_pkg::ByteW;
  localparam int unsigned CntW     = mpurb_pkg::CntW;
  localparam int unsigned PortW    = mpurb_pkg::PortW;

  mpurb_pkg::ptr_t tx_wp_q [NumPorts];
  mpurb_pkg::ptr_t tx_rp_q [NumPorts];
  mpurb_pkg::ptr_t rx_wp_q [NumPorts];
  mpurb_pkg::ptr_t rx_rp_q [NumPorts];
  mpurb_pkg::ptr_t tx_wp_d [NumPorts];
  mpurb_pkg::ptr_t tx_rp_d [NumPorts];
  mpurb_pkg::ptr_t rx_wp_d [NumPorts];
  mpurb_pkg::ptr_t rx_rp_d [NumPorts];
  logic [NumPorts-1:0]           snd_q, snd_d;
  logic [mpurb_pkg::OpenBits-1:0] mask_q, mask_d;

  logic             fire;
  logic             valid_port;
  logic             port_open;
  logic [PortSelW-1:0] pidx;

  logic             tx_we, tx_re, rx_we, rx_re;
  logic [AddrW-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
  logic [ByteW-1:0] tx_rdata, rx_rdata;

  logic             acc, lv, rv, fwd, busy_flag;
  logic [CntW-1:0]  cnt;

  logic             done_q;
  logic             acc_q, lv_q, rv_q, fwd_q, busy_flag_q;
  logic [CntW-1:0]  cnt_q;
  logic [ByteW-1:0] dbyte_q;

  assign busy_o     = cfg_we_i;
  assign fire       = start_i && !busy_o;
  assign valid_port = {1'b0, req_i.port_index} < (PortW+1)'(NumPorts);
  assign pidx       = PortSelW'(req_i.port_index);
  assign port_open  = valid_port && ({1'b0, req_i.port_index} < (PortW+1)'(mpurb_pkg::MaskPorts))
                      && mask_q[req_i.port_index];

  always_comb begin
    mpurb_pkg::ptr_t twp, trp, rwp, rrp, nxt;
    logic snd;

    tx_wp_d = tx_wp_q;
    tx_rp_d = tx_rp_q;
    rx_wp_d = rx_wp_q;
    rx_rp_d = rx_rp_q;
    snd_d   = snd_q;
    mask_d  = mask_q;

    twp = tx_wp_q[pidx];
    trp = tx_rp_q[pidx];
    rwp = rx_wp_q[pidx];
    rrp = rx_rp_q[pidx];
    snd = snd_q[pidx];
    nxt = '0;

    tx_we = 1'b0; tx_re = 1'b0; rx_we = 1'b0; rx_re = 1'b0;
    tx_waddr = mpurb_pkg::ram_addr(req_i.port_index, twp);
    tx_raddr = mpurb_pkg::ram_addr(req_i.port_index, trp);
    rx_waddr = mpurb_pkg::ram_addr(req_i.port_index, rwp);
    rx_raddr = mpurb_pkg::ram_addr(req_i.port_index, rrp);

    acc = 1'b0; lv = 1'b0; rv = 1'b0; fwd = 1'b0; busy_flag = 1'b0; cnt = '0;

    if (cfg_we_i) begin
      mask_d = cfg_wdata_i;
      for (int p = 0; p < int'(mpurb_pkg::MaskPorts); p++) begin
        if (cfg_wdata_i[p] && !mask_q[p]) begin
          tx_wp_d[p] = '0;
          tx_rp_d[p] = '0;
          rx_wp_d[p] = '0;
          rx_rp_d[p] = '0;
          snd_d[p]   = 1'b0;
        end
      end
    end else if (fire && valid_port) begin
      case (mpurb_pkg::action_e'(req_i.action))
        mpurb_pkg::ActTxPush: begin
          if (port_open) begin
            acc   = 1'b1;
            tx_we = 1'b1;
            nxt   = mpurb_pkg::bump(twp);
            if (nxt == trp) begin
              trp = mpurb_pkg::bump(trp);
            end
            // An idle port hands a byte to the line at once; when it is the
            // byte being written, the RAM read is bypassed.
            if (!snd && (nxt != trp)) begin
              lv       = 1'b1;
              tx_re    = 1'b1;
              tx_raddr = mpurb_pkg::ram_addr(req_i.port_index, trp);
              fwd      = (trp == twp);
              trp      = mpurb_pkg::bump(trp);
              snd      = 1'b1;
            end
            twp = nxt;
          end
        end
        mpurb_pkg::ActTxDone: begin
          if (port_open) begin
            acc = 1'b1;
            if (twp == trp) begin
              snd = 1'b0;
            end else begin
              lv    = 1'b1;
              tx_re = 1'b1;
              trp   = mpurb_pkg::bump(trp);
              snd   = 1'b1;
            end
          end
        end
        mpurb_pkg::ActRxPush: begin
          acc   = 1'b1;
          rx_we = 1'b1;
          if (mpurb_pkg::bump(rwp) == rrp) begin
            rrp = mpurb_pkg::bump(rrp);
          end
          rwp = mpurb_pkg::bump(rwp);
        end
        mpurb_pkg::ActRxPop: begin
          if (port_open) begin
            acc = 1'b1;
            if (rwp != rrp) begin
              rv    = 1'b1;
              rx_re = 1'b1;
              rrp   = mpurb_pkg::bump(rrp);
            end
          end
        end
        mpurb_pkg::ActRxLevel: begin
          acc = port_open;
        end
        default: begin
          acc = 1'b0;
        end
      endcase
      tx_wp_d[pidx] = twp;
      tx_rp_d[pidx] = trp;
      rx_wp_d[pidx] = rwp;
      rx_rp_d[pidx] = rrp;
      snd_d[pidx]   = snd;
      busy_flag     = snd;
      if (port_open) begin
        cnt = CntW'(mpurb_pkg::fill(rwp, rrp));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wp_q <= '{default: '0};
      tx_rp_q <= '{default: '0};
      rx_wp_q <= '{default: '0};
      rx_rp_q <= '{default: '0};
      snd_q   <= '0;
      mask_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      tx_wp_q <= tx_wp_d;
      tx_rp_q <= tx_rp_d;
      rx_wp_q <= rx_wp_d;
      rx_rp_q <= rx_rp_d;
      snd_q   <= snd_d;
      mask_q  <= mask_d;
      done_q  <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_q       <= acc;
      lv_q        <= lv;
      rv_q        <= rv;
      fwd_q       <= fwd;
      busy_flag_q <= busy_flag;
      cnt_q       <= cnt;
      dbyte_q     <= req_i.data_byte;
    end
  end

  mpurb_ram #(
    .Width(ByteW),
    .Depth(mpurb_pkg::MemDepth)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (tx_we),
    .waddr_i(tx_waddr),
    .wdata_i(req_i.data_byte),
    .re_i   (tx_re),
    .raddr_i(tx_raddr),
    .rdata_o(tx_rdata)
  );

  mpurb_ram #(
    .Width(ByteW),
    .Depth(mpurb_pkg::MemDepth)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .we_i   (rx_we),
    .waddr_i(rx_waddr),
    .wdata_i(req_i.data_byte),
    .re_i   (rx_re),
    .raddr_i(rx_raddr),
    .rdata_o(rx_rdata)
  );

  assign done_o           = done_q;
  assign rsp_o.accepted   = acc_q;
  assign rsp_o.line_valid = lv_q;
  assign rsp_o.line_byte  = lv_q ? (fwd_q ? dbyte_q : tx_rdata) : '0;
  assign rsp_o.read_valid = rv_q;
  assign rsp_o.read_byte  = rv_q ? rx_rdata : '0;
  assign rsp_o.rx_count   = cnt_q;
  assign rsp_o.tx_busy    = busy_flag_q;

  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> done_o)
    else $error("request taken without a response in the next cycle");

  a_no_resp_without_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> !done_o)
    else $error("response without a request");

  a_line_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.line_valid || rsp_o.read_valid) |-> rsp_o.accepted)
    else $error("byte returned for a refused request");

  a_one_byte_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.line_valid && rsp_o.read_valid))
    else $error("line byte and read byte in one response");

  for (genvar gp = 0; gp < NumPorts; gp++) begin : g_idle_empty
    a_idle_means_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !snd_q[gp] |-> (tx_wp_q[gp] == tx_rp_q[gp]))
      else $error("idle transmitter with bytes left in its ring");
  end

endmodule
